@@ hdl/magnetometer_sample_correction_macros.svh @@
// Assertion macros used by the checker of the magnetometer correction block.
// Depends on nothing; included by hdl/msc_chk.sv.
`ifndef MAGNETOMETER_SAMPLE_CORRECTION_MACROS_SVH
`define MAGNETOMETER_SAMPLE_CORRECTION_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define MSC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define MSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/msc_pkg.sv @@
// Shared widths, constants, FSM state type and control structs for the
// magnetometer sample correction block. No dependencies.
package msc_pkg;

	// Field widths
	localparam int RAW_W     = 16;
	localparam int ADJ_W     = 8;
	localparam int GAIN_W    = 9;
	localparam int GAIN_OFS  = 128;
	localparam int P1_W      = 25;
	localparam int P2_W      = 38;
	localparam int SCALE_K   = 6141;
	localparam int FRAC_SH   = 16;
	localparam int FIELD_W   = 22;
	localparam int SUM_W     = 29;
	localparam int OFS_W     = 18;
	localparam int OFS_SH    = 4;
	localparam int OVF_BIT   = 3;
	localparam int IDX_W     = 2;

	// Stream payload widths
	localparam int IN_DATA_W  = 56;
	localparam int IN_USER_W  = 1;
	localparam int OUT_DATA_W = 72;
	localparam int OUT_USER_W = 3;

	// Configuration register indexes
	localparam logic [IDX_W-1:0] REG_ADJ_X = 2'd0;
	localparam logic [IDX_W-1:0] REG_ADJ_Y = 2'd1;
	localparam logic [IDX_W-1:0] REG_ADJ_Z = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL1,
		ST_MUL2,
		ST_UPD,
		ST_DLOAD,
		ST_DSTEP,
		ST_DDONE
	} state_t;

	// Controller to lanes
	typedef struct packed {
		logic capture;
		logic clear_sum;
		logic add_sum;
		logic use_offset;
		logic div_load;
		logic div_step;
		logic div_done;
	} ctl_t;

	// Controller to result register
	typedef struct packed {
		logic load;
		logic zero;
		logic overflow;
		logic calibrating;
		logic updated;
	} res_t;

endpackage

@@ hdl/msc_lane.sv @@
// One axis lane: sensitivity scaling in two multiply stages, offset removal
// with saturation, calibration sum and a reciprocal-multiply offset divider.
// Uses msc_pkg.
module msc_lane #(
	parameter int CALIB_SAMPLES = 100
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  msc_pkg::ctl_t                      ctl,
	input  logic [msc_pkg::RAW_W-1:0]          raw,
	input  logic [msc_pkg::ADJ_W-1:0]          adjust,
	output logic signed [msc_pkg::FIELD_W-1:0] field
);
	import msc_pkg::*;

	// |sum| / 16 is a shift; the rest is floor(mag * ceil(2^RCP_SH / N) / 2^RCP_SH),
	// exact for every magnitude below 2^MAG_W
	localparam int MAG_W  = SUM_W - 1 - OFS_SH;
	localparam int RCP_SH = MAG_W + $clog2(CALIB_SAMPLES);
	localparam int RCP_W  = MAG_W + 2;
	localparam int QP_W   = MAG_W + RCP_W;
	localparam longint RCP_L = ((longint'(1) <<< RCP_SH) + longint'(CALIB_SAMPLES) - 1)
		/ longint'(CALIB_SAMPLES);
	localparam logic [RCP_W-1:0] RCP_C = RCP_W'(RCP_L);
	localparam logic signed [P2_W-1:0] K_C = P2_W'(SCALE_K);
	localparam logic signed [FIELD_W:0] SAT_HI = (FIELD_W+1)'((1 << (FIELD_W-1)) - 1);
	localparam logic signed [FIELD_W:0] SAT_LO = -(FIELD_W+1)'(1 << (FIELD_W-1));

	logic [RAW_W-1:0]          raw_q;
	logic signed [P1_W-1:0]    prod1_s1;
	logic signed [P2_W-1:0]    prod2_s2;
	logic signed [SUM_W-1:0]   sum_q;
	logic signed [OFS_W-1:0]   offset_q;
	logic [MAG_W-1:0]          mag_q;
	logic [QP_W-1:0]           quo_q;
	logic                      neg_q;

	logic [GAIN_W-1:0]         gain;
	logic signed [P1_W-1:0]    raw_ext;
	logic signed [P1_W-1:0]    gain_ext;
	logic signed [P2_W-1:0]    p1_ext;
	logic signed [FIELD_W-1:0] scaled;
	logic signed [FIELD_W:0]   diff;
	logic [SUM_W-1:0]          sum_mag;

	// Raw sample capture
	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			raw_q <= raw;
		end
	end

	// Gain (adjust + 128) and the two multiply stages
	assign gain     = GAIN_W'({1'b0, adjust}) + GAIN_W'(GAIN_OFS);
	assign raw_ext  = {{(P1_W-RAW_W){raw_q[RAW_W-1]}}, raw_q};
	assign gain_ext = {{(P1_W-GAIN_W){1'b0}}, gain};
	assign p1_ext   = {{(P2_W-P1_W){prod1_s1[P1_W-1]}}, prod1_s1};

	always_ff @(posedge clk) begin
		prod1_s1 <= raw_ext * gain_ext;
		prod2_s2 <= p1_ext * K_C;
	end

	// Floor shift by 16; the value always fits the field width
	assign scaled = prod2_s2[FRAC_SH +: FIELD_W];

	// Offset removal with saturation
	assign diff = {scaled[FIELD_W-1], scaled}
		- {offset_q[OFS_W-1], offset_q, {OFS_SH{1'b0}}};

	always_comb begin
		field = scaled;
		if (ctl.use_offset) begin
			if (diff > SAT_HI) begin
				field = SAT_HI[FIELD_W-1:0];
			end else if (diff < SAT_LO) begin
				field = SAT_LO[FIELD_W-1:0];
			end else begin
				field = diff[FIELD_W-1:0];
			end
		end
	end

	// Sum magnitude; the sum never reaches full negative scale
	assign sum_mag = sum_q[SUM_W-1] ? (~sum_q + SUM_W'(1)) : sum_q;

	// Calibration sum and offset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q    <= '0;
			offset_q <= '0;
		end else begin
			if (ctl.clear_sum) begin
				sum_q <= '0;
			end else if (ctl.add_sum) begin
				sum_q <= sum_q + {{(SUM_W-FIELD_W){scaled[FIELD_W-1]}}, scaled};
			end
			if (ctl.div_done) begin
				offset_q <= neg_q ? -quo_q[RCP_SH +: OFS_W] : quo_q[RCP_SH +: OFS_W];
			end
		end
	end

	// Divider datapath: shifted magnitude, then one reciprocal multiply
	always_ff @(posedge clk) begin
		if (ctl.div_load) begin
			neg_q <= sum_q[SUM_W-1];
			mag_q <= sum_mag[SUM_W-2:OFS_SH];
		end
		if (ctl.div_step) begin
			quo_q <= mag_q * RCP_C;
		end
	end

endmodule

@@ hdl/msc_ctrl.sv @@
// Sequencer for the correction block: item handshake, calibration count,
// divider stepping and result flags. Uses msc_pkg.
module msc_ctrl #(
	parameter int CALIB_SAMPLES = 100
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic          op,
	input  logic          ovf_in,
	input  logic          out_free,
	output msc_pkg::ctl_t ctl,
	output msc_pkg::res_t res
);
	import msc_pkg::*;

	localparam int CNT_W = $clog2(CALIB_SAMPLES + 1);

	state_t           state_q;
	state_t           state_nx;
	logic             op_q;
	logic             ovf_q;
	logic             cal_q;
	logic [CNT_W-1:0] cnt_q;

	logic             upd_go;
	logic             good;
	logic             done;
	logic [CNT_W:0]   cnt_inc;

	assign upd_go  = (state_q == ST_UPD) && out_free;
	assign good    = !op_q && !ovf_q;
	assign cnt_inc = {1'b0, cnt_q} + (CNT_W+1)'(1);
	assign done    = good && cal_q && (cnt_inc >= (CNT_W+1)'(CALIB_SAMPLES));

	// Next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE:  if (s_tvalid) begin
				state_nx = ST_MUL1;
			end
			ST_MUL1:  state_nx = ST_MUL2;
			ST_MUL2:  state_nx = ST_UPD;
			ST_UPD:   if (out_free) begin
				state_nx = done ? ST_DLOAD : ST_IDLE;
			end
			ST_DLOAD: state_nx = ST_DSTEP;
			ST_DSTEP: state_nx = ST_DDONE;
			ST_DDONE: state_nx = ST_IDLE;
			default:  state_nx = ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		s_tready        = (state_q == ST_IDLE);
		ctl.capture     = s_tvalid && (state_q == ST_IDLE);
		ctl.clear_sum   = upd_go && op_q;
		ctl.add_sum     = upd_go && good && cal_q;
		ctl.use_offset  = !cal_q;
		ctl.div_load    = (state_q == ST_DLOAD);
		ctl.div_step    = (state_q == ST_DSTEP);
		ctl.div_done    = (state_q == ST_DDONE);
		res.load        = upd_go;
		res.zero        = !good;
		res.overflow    = ovf_q && !op_q;
		res.calibrating = op_q || (cal_q && !done);
		res.updated     = done;
	end

	// State, item flags and calibration progress
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= 1'b0;
			ovf_q   <= 1'b0;
			cal_q   <= 1'b1;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nx;
			if (ctl.capture) begin
				op_q  <= op;
				ovf_q <= ovf_in;
			end
			if (upd_go) begin
				if (op_q) begin
					cnt_q <= '0;
					cal_q <= 1'b1;
				end else if (good && cal_q) begin
					cnt_q <= cnt_inc[CNT_W-1:0];
					if (done) begin
						cal_q <= 1'b0;
					end
				end
			end
		end
	end

endmodule

@@ hdl/magnetometer_sample_correction.sv @@
// Magnetometer sample correction: scales each axis by its factory adjust byte,
// removes a learned hard-iron offset and swaps X and Y. Requests go one at a
// time through accept, two multiply stages and update, which waits for a free
// output register. One that ends a calibration run adds magnitude load,
// reciprocal multiply and offset load while each lane turns its sum into an
// offset, accepting no request. A finished result waits in the output
// register while the next request is taken. Reset starts a calibration over
// CALIB_SAMPLES good readings. Depends on msc_pkg, msc_ctrl and msc_lane.
module magnetometer_sample_correction #(
	parameter int CALIB_SAMPLES = 100
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// x_low, x_high, y_low, y_high, z_low, z_high, status_two
	input  logic [msc_pkg::IN_DATA_W-1:0]      s_tdata,
	// op
	input  logic [msc_pkg::IN_USER_W-1:0]      s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// field_x, field_y, field_z, zero pad
	output logic [msc_pkg::OUT_DATA_W-1:0]     m_tdata,
	// overflow, calibrating, offset_updated
	output logic [msc_pkg::OUT_USER_W-1:0]     m_tuser,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [msc_pkg::IDX_W-1:0]          cfg_index,
	input  logic [msc_pkg::ADJ_W-1:0]          cfg_data
);
	import msc_pkg::*;

	ctl_t ctl;
	res_t res;

	logic [ADJ_W-1:0] adj_x_q;
	logic [ADJ_W-1:0] adj_y_q;
	logic [ADJ_W-1:0] adj_z_q;

	logic signed [FIELD_W-1:0] lane_fx;
	logic signed [FIELD_W-1:0] lane_fy;
	logic signed [FIELD_W-1:0] lane_fz;

	logic                     m_tvalid_q;
	logic [OUT_DATA_W-1:0]    m_tdata_q;
	logic [OUT_USER_W-1:0]    m_tuser_q;
	logic                     out_free;

	// Adjust registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			adj_x_q <= ADJ_W'(GAIN_OFS);
			adj_y_q <= ADJ_W'(GAIN_OFS);
			adj_z_q <= ADJ_W'(GAIN_OFS);
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_ADJ_X: adj_x_q <= cfg_data;
				REG_ADJ_Y: adj_y_q <= cfg_data;
				REG_ADJ_Z: adj_z_q <= cfg_data;
				default:   ;
			endcase
		end
	end

	assign out_free = !m_tvalid_q || m_tready;

	msc_ctrl #(
		.CALIB_SAMPLES(CALIB_SAMPLES)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.op       (s_tuser[0]),
		.ovf_in   (s_tdata[48 + OVF_BIT]),
		.out_free (out_free),
		.ctl      (ctl),
		.res      (res)
	);

	// Output X lane works on raw Y
	msc_lane #(
		.CALIB_SAMPLES(CALIB_SAMPLES)
	) u_lane_x (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.raw    ({s_tdata[31:24], s_tdata[23:16]}),
		.adjust (adj_y_q),
		.field  (lane_fx)
	);

	// Output Y lane works on raw X
	msc_lane #(
		.CALIB_SAMPLES(CALIB_SAMPLES)
	) u_lane_y (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.raw    ({s_tdata[15:8], s_tdata[7:0]}),
		.adjust (adj_x_q),
		.field  (lane_fy)
	);

	msc_lane #(
		.CALIB_SAMPLES(CALIB_SAMPLES)
	) u_lane_z (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.raw    ({s_tdata[47:40], s_tdata[39:32]}),
		.adjust (adj_z_q),
		.field  (lane_fz)
	);

	// Merge lanes into the output register
	always_ff @(posedge clk) begin
		if (res.load) begin
			if (res.zero) begin
				m_tdata_q <= '0;
			end else begin
				m_tdata_q <= {{(OUT_DATA_W - 3*FIELD_W){1'b0}}, lane_fz, lane_fy, lane_fx};
			end
			m_tuser_q <= {res.updated, res.calibrating, res.overflow};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res.load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

@@ hdl/msc_chk.sv @@
// Port-level checker for the magnetometer correction block and its bind.
// Depends on msc_pkg and magnetometer_sample_correction_macros.svh.
`include "magnetometer_sample_correction_macros.svh"

module msc_chk (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [msc_pkg::OUT_DATA_W-1:0] m_tdata,
	input logic [msc_pkg::OUT_USER_W-1:0] m_tuser
);
	import msc_pkg::*;

	// Held result stays put
	`MSC_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

	// Discarded reading carries zero fields
	`MSC_ASSERT_NOW(a_ovf_zero, clk, arst_n, m_tvalid && m_tuser[0], m_tdata == '0, "overflow result with nonzero fields")

	// Completing calibration ends the calibrating flag and shows no overflow
	`MSC_ASSERT_NOW(a_upd_cal, clk, arst_n, m_tvalid && m_tuser[2], !m_tuser[1] && !m_tuser[0], "offset update flags inconsistent")

	// One request at a time: not ready right after an accept
	`MSC_ASSERT_NEXT(a_one_item, clk, arst_n, s_tvalid && s_tready, !s_tready, "request accepted while busy")

endmodule

bind magnetometer_sample_correction msc_chk u_msc_chk (.*);

@@ sim/testbench.sv @@
// Self-checking bench for magnetometer_sample_correction: directed rows, then random
// calibration and measurement runs under varying idle patterns on both stream sides.
// Depends on msc_pkg and the magnetometer_sample_correction RTL.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import msc_pkg::*;

	localparam int CALIB_SAMPLES = 100;
	localparam int DRAIN_PAUSE   = 40;
	localparam int PHASE_ITEMS   = 240;
	localparam longint FIELD_MAX = 2097151;
	localparam longint FIELD_MIN = -2097152;

	typedef enum logic [0:0] {
		OP_SAMPLE    = 1'b0,
		OP_CALIBRATE = 1'b1
	} op_e;

	// One corrected reading as it leaves the block
	typedef struct packed {
		logic [FIELD_W-1:0] fx;
		logic [FIELD_W-1:0] fy;
		logic [FIELD_W-1:0] fz;
		logic               overflow;
		logic               calibrating;
		logic               updated;
	} corrected_t;

	typedef struct {
		op_e                op;
		logic [IN_DATA_W-1:0] data;
		bit                 typed;
		logic [FIELD_W-1:0] fx;
		logic [FIELD_W-1:0] fy;
		logic [FIELD_W-1:0] fz;
		bit                 overflow;
		bit                 calibrating;
		bit                 updated;
	} row_t;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic [IN_USER_W-1:0]  s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [OUT_USER_W-1:0] m_tuser;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [IDX_W-1:0]      cfg_index = '0;
	logic [ADJ_W-1:0]      cfg_data = '0;

	// Mirror of the block state and adjust registers
	logic [ADJ_W-1:0] gain_x = 8'd128;
	logic [ADJ_W-1:0] gain_y = 8'd128;
	logic [ADJ_W-1:0] gain_z = 8'd128;
	longint           cal_sum [3] = '{0, 0, 0};
	longint           hard_iron [3] = '{0, 0, 0};
	int               cal_count = 0;
	bit               cal_active = 1'b1;

	corrected_t corrected_pending [$];
	int         failures = 0;
	int         readings_sent = 0;
	int         send_idle_pct = 7;
	int         recv_idle_pct = 60;

	// data = {status_two, z_high, z_low, y_high, y_low, x_high, x_low}
	row_t directed_rows [14] = '{
		'{OP_SAMPLE,    56'h08_FFFF_FFFF_FFFF, 1'b1, 0, 0, 0, 1'b1, 1'b1, 1'b0},
		'{OP_CALIBRATE, 56'hFF_FFFF_FFFF_FFFF, 1'b1, 0, 0, 0, 1'b0, 1'b1, 1'b0},
		'{OP_SAMPLE,    56'h00_0000_0000_0000, 1'b1, 0, 0, 0, 1'b0, 1'b1, 1'b0},
		'{OP_SAMPLE,    56'hF7_0001_8000_7FFF, 1'b0, 0, 0, 0, 1'b0, 1'b0, 1'b0},
		'{OP_SAMPLE,    56'h00_FFFF_7FFF_8000, 1'b0, 0, 0, 0, 1'b0, 1'b0, 1'b0},
		'{OP_SAMPLE,    56'h00_8000_FFFF_0001, 1'b0, 0, 0, 0, 1'b0, 1'b0, 1'b0},
		'{OP_SAMPLE,    56'hFF_1234_5678_9ABC, 1'b1, 0, 0, 0, 1'b1, 1'b1, 1'b0},
		'{OP_SAMPLE,    56'h01_00FF_0100_0080, 1'b0, 0, 0, 0, 1'b0, 1'b0, 1'b0},
		'{OP_SAMPLE,    56'h80_7F00_FF00_00FF, 1'b0, 0, 0, 0, 1'b0, 1'b0, 1'b0},
		'{OP_SAMPLE,    56'h00_0000_0000_0000, 1'b1, 0, 0, 0, 1'b0, 1'b1, 1'b0},
		'{OP_CALIBRATE, 56'h00_0000_0000_0000, 1'b1, 0, 0, 0, 1'b0, 1'b1, 1'b0},
		'{OP_SAMPLE,    56'h77_7FFF_7FFF_7FFF, 1'b0, 0, 0, 0, 1'b0, 1'b0, 1'b0},
		'{OP_SAMPLE,    56'hF7_8000_8000_8000, 1'b0, 0, 0, 0, 1'b0, 1'b0, 1'b0},
		'{OP_SAMPLE,    56'h08_0000_0000_0000, 1'b1, 0, 0, 0, 1'b1, 1'b1, 1'b0}
	};

	magnetometer_sample_correction #(
		.CALIB_SAMPLES(CALIB_SAMPLES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// floor(raw * (adj + 128) * 6141 / 2^16)
	function automatic longint scale_axis(input logic [15:0] raw, input logic [7:0] adj);
		longint p;
		p = longint'($signed(raw)) * (longint'(adj) + 128) * 6141;
		return p >>> 16;
	endfunction

	function automatic logic [FIELD_W-1:0] clamp22(input longint v);
		if (v > FIELD_MAX)
			return FIELD_MAX[FIELD_W-1:0];
		if (v < FIELD_MIN)
			return FIELD_MIN[FIELD_W-1:0];
		return v[FIELD_W-1:0];
	endfunction

	// Advance the mirrored state by one accepted request and return its result
	function automatic corrected_t apply_reading(input op_e op, input logic [IN_DATA_W-1:0] data);
		corrected_t res;
		longint     scaled [3];
		longint     fld [3];
		res = '0;
		fld = '{0, 0, 0};
		if (op == OP_CALIBRATE) begin
			cal_sum = '{0, 0, 0};
			cal_count = 0;
			cal_active = 1'b1;
		end else if (data[48 + OVF_BIT]) begin
			res.overflow = 1'b1;
		end else begin
			// output order is raw Y, raw X, raw Z
			scaled[0] = scale_axis(data[31:16], gain_y);
			scaled[1] = scale_axis(data[15:0], gain_x);
			scaled[2] = scale_axis(data[47:32], gain_z);
			if (cal_active) begin
				for (int i = 0; i < 3; i++) begin
					cal_sum[i] += scaled[i];
					fld[i] = scaled[i];
				end
				cal_count++;
				if (cal_count >= CALIB_SAMPLES) begin
					// signed divide truncates toward zero
					for (int i = 0; i < 3; i++)
						hard_iron[i] = cal_sum[i] / (CALIB_SAMPLES * 16);
					cal_active = 1'b0;
					res.updated = 1'b1;
				end
			end else begin
				for (int i = 0; i < 3; i++)
					fld[i] = scaled[i] - 16 * hard_iron[i];
			end
		end
		res.fx = clamp22(fld[0]);
		res.fy = clamp22(fld[1]);
		res.fz = clamp22(fld[2]);
		res.calibrating = cal_active;
		return res;
	endfunction

	// bias 0: anything, +1: near positive full scale, -1: near negative full scale
	function automatic logic [15:0] pick_raw(input int bias);
		logic [15:0] corners [4];
		corners = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF};
		if (bias > 0)
			return 16'h7FFF - 16'($urandom_range(255));
		if (bias < 0)
			return 16'h8000 + 16'($urandom_range(255));
		if ($urandom_range(9) == 0)
			return corners[$urandom_range(3)];
		return 16'($urandom);
	endfunction

	function automatic logic [IN_DATA_W-1:0] make_reading(input int bias, input int ovf_pct);
		logic [7:0] status;
		status = 8'($urandom);
		if ($urandom_range(99) < ovf_pct)
			status[OVF_BIT] = 1'b1;
		else
			status[OVF_BIT] = 1'b0;
		return {status, pick_raw(bias), pick_raw(bias), pick_raw(bias)};
	endfunction

	// Send one request; its expected result is queued on acceptance
	task automatic push_reading(input op_e op, input logic [IN_DATA_W-1:0] data,
			input bit typed, input corrected_t want);
		corrected_t res;
		if ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct)
				@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= data;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		res = apply_reading(op, data);
		corrected_pending.push_back(typed ? want : res);
		readings_sent++;
	endtask

	task automatic push_sample(input op_e op, input logic [IN_DATA_W-1:0] data);
		push_reading(op, data, 1'b0, '0);
	endtask

	// Stop sending and let every outstanding result come back
	task automatic drain;
		s_tvalid <= 1'b0;
		while (corrected_pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_PAUSE) @(posedge clk);
	endtask

	// Write all three adjust registers back to back; block must be idle
	task automatic load_adjust(input logic [7:0] ax, input logic [7:0] ay, input logic [7:0] az);
		logic [IDX_W-1:0] regs [3];
		logic [7:0]       vals [3];
		regs = '{REG_ADJ_X, REG_ADJ_Y, REG_ADJ_Z};
		vals = '{ax, ay, az};
		for (int i = 0; i < 3; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= regs[i];
			cfg_data <= vals[i];
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
			case (regs[i])
				REG_ADJ_X: gain_x = vals[i];
				REG_ADJ_Y: gain_y = vals[i];
				REG_ADJ_Z: gain_z = vals[i];
				default: ;
			endcase
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			failures++;
		end
	endtask

	// Result side: random backpressure, compare each accepted result in order
	initial begin
		corrected_t want;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) begin
				if (corrected_pending.size() == 0) begin
					$error("result with no request outstanding: tdata %h tuser %b",
						m_tdata, m_tuser);
					failures++;
				end else begin
					want = corrected_pending.pop_front();
					check_field("field_x", $signed(want.fx), $signed(m_tdata[21:0]));
					check_field("field_y", $signed(want.fy), $signed(m_tdata[43:22]));
					check_field("field_z", $signed(want.fz), $signed(m_tdata[65:44]));
					check_field("overflow", want.overflow, m_tuser[0]);
					check_field("calibrating", want.calibrating, m_tuser[1]);
					check_field("offset_updated", want.updated, m_tuser[2]);
				end
			end
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Stimulus
	initial begin
		corrected_t want;
		int         episode;
		int         kind;
		int         bias;
		int         meas_bias;
		int         meas_len;
		int         phase_start;
		logic [7:0] adj;
		episode = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows at reset defaults
		foreach (directed_rows[i]) begin
			want = '0;
			want.fx = directed_rows[i].fx;
			want.fy = directed_rows[i].fy;
			want.fz = directed_rows[i].fz;
			want.overflow = directed_rows[i].overflow;
			want.calibrating = directed_rows[i].calibrating;
			want.updated = directed_rows[i].updated;
			push_reading(directed_rows[i].op, directed_rows[i].data, directed_rows[i].typed, want);
		end

		// Random runs: calibrate, then measure, under three idle patterns
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 7;
					recv_idle_pct = 60;
				end
				1: begin
					send_idle_pct = 60;
					recv_idle_pct = 7;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			phase_start = readings_sent;
			while (readings_sent - phase_start < PHASE_ITEMS) begin
				kind = episode % 3;
				episode++;
				drain();
				// zero and full-scale adjust bytes, then random ones
				case (kind)
					0: load_adjust(8'h00, 8'h00, 8'h00);
					1: load_adjust(8'hFF, 8'hFF, 8'hFF);
					default: load_adjust(8'($urandom), 8'($urandom), 8'($urandom));
				endcase
				if (kind == 1)
					bias = $urandom_range(1) ? 1 : -1;
				else
					bias = int'($urandom_range(2)) - 1;

				// calibration run with overflow noise and the odd restart
				push_sample(OP_CALIBRATE, IN_DATA_W'({$urandom, $urandom}));
				while (cal_active) begin
					if ($urandom_range(199) == 0)
						push_sample(OP_CALIBRATE, IN_DATA_W'({$urandom, $urandom}));
					else
						push_sample(OP_SAMPLE, make_reading(bias, 6));
				end

				// new gain after the offsets are learned
				if (kind == 2) begin
					drain();
					adj = 8'($urandom);
					load_adjust(adj, 8'($urandom), ~adj);
				end

				// measurements, often at the far side of the learned offset
				meas_len = $urandom_range(20, 60);
				for (int n = 0; n < meas_len; n++) begin
					meas_bias = ($urandom_range(2) == 0) ? -bias : 0;
					if ($urandom_range(99) == 0)
						push_sample(OP_CALIBRATE, IN_DATA_W'({$urandom, $urandom}));
					else
						push_sample(OP_SAMPLE, make_reading(meas_bias, 6));
				end
			end
		end

		drain();
		if (failures == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// Hang guard, far beyond the slowest legal run
	initial begin
		#10ms;
		$display("status: fail");
		$finish;
	end

endmodule
